/* src/assert_macros.svh */
// Assertion macros for the RTL; included by life_automaton_torus.
// No dependencies; every macro samples on clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lat_pkg.sv */
// Types, request codes and helpers for the toroidal life automaton.
// No dependencies.
`timescale 1ns / 1ps

package lat_pkg;

   localparam int DIM_W = 11;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_STEP = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic [7:0] LEVEL_ALIVE_LIMIT = 8'h80;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] col;
      logic [5:0] row;
      logic [7:0] pixel_level;
   } req_payload_type;

   typedef struct packed {
      logic cell_alive;
      logic coord_error;
   } rsp_payload_type;

   typedef struct packed {
      logic step;
      logic load;
      logic load_val;
   } cell_ctl_type;

   // A size of zero acts as one; above the maximum it acts as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] ext;
      ext = {{(DIM_W-7){1'b0}}, v};
      if (ext == '0) return DIM_W'(1);
      if (ext > maxv) return maxv;
      return ext;
   endfunction

endpackage

/* src/lat_row_cell.sv */
// One row of the grid: holds its cells and computes their next generation.
// Depends on lat_pkg; neighbor rows arrive from the adjacent cells of the chain.
`timescale 1ns / 1ps

module lat_row_cell #(
   parameter int MAX_COLS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lat_pkg::cell_ctl_type      ctl,
   input  logic                       row_active,
   input  logic [lat_pkg::DIM_W-1:0]  width,
   input  logic [$clog2(MAX_COLS)-1:0] load_col,
   input  logic [MAX_COLS-1:0]        row_up,
   input  logic [MAX_COLS-1:0]        row_dn,
   output logic [MAX_COLS-1:0]        row_out
);

   localparam int CIW = $clog2(MAX_COLS);

   logic [MAX_COLS-1:0]       bits_ff;
   logic [MAX_COLS-1:0]       bits_in;
   logic [lat_pkg::DIM_W-1:0] wm1;
   logic [CIW-1:0]            last_col;

   assign wm1      = width - lat_pkg::DIM_W'(1);
   assign last_col = wm1[CIW-1:0];
   assign row_out  = bits_ff;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic [CIW-1:0] li, ri;
      logic [7:0]     nb;
      logic [3:0]     cnt;
      logic           next_bit;
      logic           in_grid;

      // The left neighbor of column zero and the right neighbor of the last
      // column wrap to the other edge of the configured width.
      assign li = (c == 0) ? last_col : CIW'(c - 1);
      assign ri = (lat_pkg::DIM_W'(c) == wm1) ? '0 : CIW'(c + 1);
      assign nb = {row_up[li], row_up[CIW'(c)], row_up[ri], bits_ff[li], bits_ff[ri],
                   row_dn[li], row_dn[CIW'(c)], row_dn[ri]};
      assign cnt = 4'($countones(nb));
      assign next_bit = bits_ff[c] ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);
      assign in_grid = row_active && (lat_pkg::DIM_W'(c) < width);

      always_comb begin
         bits_in[c] = bits_ff[c];
         if (ctl.step && in_grid) begin
            bits_in[c] = next_bit;
         end else if (ctl.load && load_col == CIW'(c)) begin
            bits_in[c] = ctl.load_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

endmodule

/* src/life_automaton_torus.sv */
// Top level of the toroidal life automaton: configuration, request decode,
// the chain of row cells and the result register. Depends on lat_pkg,
// lat_row_cell and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  lat_pkg::req_payload_type
//   rsp      out        rsp_valid / rsp_stall  lat_pkg::rsp_payload_type
//   csr      in         csr_we                 csr_index, csr_data
//
// Every item, load, read or step, gives one result; a step updates all rows
// within the configured height at once, each cell counting from its own and its neighbors' rows.
// The result is in the output register the cycle after the transfer.
// Reset clears all cells and sets both grid sizes to 64.
// A new item is taken while the held result is being transferred or absent.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module life_automaton_torus #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lat_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lat_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [6:0]               csr_data
);

   localparam int CIW = $clog2(MAX_COLS);
   localparam int RIW = $clog2(MAX_ROWS);
   localparam int DW  = lat_pkg::DIM_W;

   logic [6:0]               width_cfg_ff, width_cfg_in;
   logic [6:0]               height_cfg_ff, height_cfg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lat_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [DW-1:0]       width, height, hm1, col_ext, row_ext;
   logic                accept, is_load, is_read, is_step, coord_err, load_val;
   logic [CIW-1:0]      col_idx;
   logic [RIW-1:0]      row_idx;
   logic [MAX_COLS-1:0] rows [MAX_ROWS];

   assign width   = lat_pkg::clamp_dim(width_cfg_ff, DW'(MAX_COLS));
   assign height  = lat_pkg::clamp_dim(height_cfg_ff, DW'(MAX_ROWS));
   assign hm1     = height - DW'(1);
   assign col_ext = DW'(req_payload.col);
   assign row_ext = DW'(req_payload.row);
   assign col_idx = col_ext[CIW-1:0];
   assign row_idx = row_ext[RIW-1:0];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_load   = req_payload.req_type == lat_pkg::REQ_LOAD;
   assign is_read   = req_payload.req_type == lat_pkg::REQ_READ;
   assign is_step   = req_payload.req_type == lat_pkg::REQ_STEP;
   assign coord_err = (col_ext >= width) || (row_ext >= height);
   assign load_val  = req_payload.pixel_level < lat_pkg::LEVEL_ALIVE_LIMIT;

   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      lat_pkg::cell_ctl_type ctl;
      logic [MAX_COLS-1:0]   up, dn;

      // Row zero and the last configured row wrap to each other.
      assign up = (r == 0) ? rows[hm1[RIW-1:0]] : rows[(r + MAX_ROWS - 1) % MAX_ROWS];
      assign dn = (DW'(r) == hm1) ? rows[0] : rows[(r + 1) % MAX_ROWS];
      assign ctl.step = accept && is_step;
      assign ctl.load = accept && is_load && !coord_err && row_idx == RIW'(r);
      assign ctl.load_val = load_val;

      lat_row_cell #(.MAX_COLS(MAX_COLS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .row_active (DW'(r) < height),
         .width      (width),
         .load_col   (col_idx),
         .row_up     (up),
         .row_dn     (dn),
         .row_out    (rows[r])
      );
   end

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_we) begin
         if (csr_index == lat_pkg::CSR_GRID_HEIGHT) begin
            height_cfg_in = csr_data;
         end else begin
            width_cfg_in = csr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.coord_error = (is_load || is_read) && coord_err;
         rsp_in.cell_alive  = 1'b0;
         if (is_load && !coord_err) begin
            rsp_in.cell_alive = load_val;
         end else if (is_read && !coord_err) begin
            rsp_in.cell_alive = rows[row_idx][col_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= 7'd64;
         height_cfg_ff <= 7'd64;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_valid_ff, "transfer without result")
   `ASSERT_NEXT(a_step_rsp_zero, accept && is_step, rsp_ff == '0, "step result not zero")
   `ASSERT_IMPL(a_err_not_alive, rsp_valid_ff && rsp_ff.coord_error, !rsp_ff.cell_alive, "error with live cell")

endmodule

/* sim/life_automaton_torus_tb.sv */
// Testbench for life_automaton_torus: a behavioral model of the toroidal life grid
// predicts every result, which a checker process compares field by field.
// Depends on lat_pkg and the life_automaton_torus RTL.
`timescale 1ns / 1ps

module life_automaton_torus_tb;

   localparam int NCOLS = 64;
   localparam int NROWS = 64;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   lat_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   lat_pkg::rsp_payload_type rsp_payload;
   logic csr_we;
   logic csr_index;
   logic [6:0] csr_data;

   life_automaton_torus dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow grid and sizes as seen by the block.
   bit grid_cells [NROWS][NCOLS];
   logic [6:0] width_reg;
   logic [6:0] height_reg;
   lat_pkg::rsp_payload_type pending_cells[$];
   int mismatches;
   int transfers_in;
   int transfers_out;
   int idle_cycles;
   bit hold_off;
   bit burst_mode;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(logic [6:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void advance_generation();
      int w, h, n, nr, nc;
      bit nxt [NROWS][NCOLS];
      w = eff_dim(width_reg, NCOLS);
      h = eff_dim(height_reg, NROWS);
      nxt = grid_cells;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr == 0 && dc == 0) continue;
                  nr = (r + h + dr) % h;
                  nc = (c + w + dc) % w;
                  n += grid_cells[nr][nc];
               end
            nxt[r][c] = grid_cells[r][c] ? (n == 2 || n == 3) : (n == 3);
         end
      grid_cells = nxt;
   endfunction

   function automatic lat_pkg::rsp_payload_type predict_cell(lat_pkg::req_payload_type p);
      lat_pkg::rsp_payload_type res;
      int w, h;
      res = '0;
      w = eff_dim(width_reg, NCOLS);
      h = eff_dim(height_reg, NROWS);
      if (p.req_type == lat_pkg::REQ_STEP) begin
         advance_generation();
      end else if (p.req_type == lat_pkg::REQ_LOAD || p.req_type == lat_pkg::REQ_READ) begin
         if (p.col >= w || p.row >= h) begin
            res.coord_error = 1'b1;
         end else begin
            if (p.req_type == lat_pkg::REQ_LOAD)
               grid_cells[p.row][p.col] = (p.pixel_level < lat_pkg::LEVEL_ALIVE_LIMIT);
            res.cell_alive = grid_cells[p.row][p.col];
         end
      end
      return res;
   endfunction

   // Prediction happens at the transfer edge, in order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_cells = {pending_cells, predict_cell(req_payload)};
         transfers_in++;
      end
   end

   always @(posedge clock) begin
      lat_pkg::rsp_payload_type exp_cell;
      if (!reset && rsp_valid && !rsp_stall) begin
         transfers_out++;
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
         end else begin
            exp_cell = pending_cells.pop_front();
            if (rsp_payload.cell_alive !== exp_cell.cell_alive ||
                rsp_payload.coord_error !== exp_cell.coord_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected alive=%0b err=%0b, got alive=%0b err=%0b",
                           exp_cell.cell_alive, exp_cell.coord_error,
                           rsp_payload.cell_alive, rsp_payload.coord_error);
            end
         end
      end
   end

   // Receiver stall pattern, with an optional long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else if (burst_mode) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Valid stays high after a transfer until the next call or a drain; a call may first drop it for a random gap.
   task automatic send_cell_op(logic [1:0] kind, logic [5:0] c, logic [5:0] r,
                               logic [7:0] lvl);
      lat_pkg::req_payload_type p;
      p.req_type = kind;
      p.col = c;
      p.row = r;
      p.pixel_level = lvl;
      if (!burst_mode && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(logic idx, logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == lat_pkg::CSR_GRID_WIDTH) width_reg = v; else height_reg = v;
   endtask

   task automatic rand_op(int w, int h);
      int k;
      k = $urandom_range(0, 19);
      if (k < 8)
         send_cell_op(lat_pkg::REQ_LOAD, 6'($urandom_range(0, w + 1 > 63 ? 63 : w + 1)),
                      6'($urandom_range(0, h + 1 > 63 ? 63 : h + 1)),
                      8'($urandom_range(0, 255)));
      else if (k < 16)
         send_cell_op(lat_pkg::REQ_READ, 6'($urandom_range(0, w + 1 > 63 ? 63 : w + 1)),
                      6'($urandom_range(0, h + 1 > 63 ? 63 : h + 1)),
                      8'($urandom_range(0, 255)));
      else if (k < 19)
         send_cell_op(lat_pkg::REQ_STEP, 6'($urandom), 6'($urandom), 8'($urandom));
      else
         send_cell_op(REQ_UNUSED, 6'($urandom), 6'($urandom), 8'($urandom));
   endtask

   task automatic test_directed();
      write_size(lat_pkg::CSR_GRID_WIDTH, 7'd5);
      write_size(lat_pkg::CSR_GRID_HEIGHT, 7'd5);
      // A blinker oscillates with period two.
      send_cell_op(lat_pkg::REQ_LOAD, 6'd1, 6'd2, 8'h00);
      send_cell_op(lat_pkg::REQ_LOAD, 6'd2, 6'd2, 8'h7f);
      send_cell_op(lat_pkg::REQ_LOAD, 6'd3, 6'd2, 8'h10);
      send_cell_op(lat_pkg::REQ_LOAD, 6'd0, 6'd0, 8'h80);
      send_cell_op(lat_pkg::REQ_LOAD, 6'd0, 6'd0, 8'hff);
      send_cell_op(lat_pkg::REQ_STEP, 6'd0, 6'd0, 8'h00);
      send_cell_op(lat_pkg::REQ_READ, 6'd2, 6'd1, 8'h00);
      send_cell_op(lat_pkg::REQ_READ, 6'd2, 6'd3, 8'hff);
      send_cell_op(lat_pkg::REQ_STEP, 6'h3f, 6'h3f, 8'hff);
      send_cell_op(lat_pkg::REQ_READ, 6'd1, 6'd2, 8'h00);
      send_cell_op(lat_pkg::REQ_READ, 6'd5, 6'd0, 8'h00);
      send_cell_op(lat_pkg::REQ_LOAD, 6'd0, 6'd5, 8'h00);
      send_cell_op(lat_pkg::REQ_READ, 6'h3f, 6'h3f, 8'h00);
      send_cell_op(REQ_UNUSED, 6'h2a, 6'h15, 8'haa);
      send_cell_op(REQ_UNUSED, 6'h15, 6'h2a, 8'h55);
   endtask

   task automatic test_sizes();
      logic [6:0] sizes [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd127, 7'd65, 7'd7};
      for (int i = 0; i < 8; i++) begin
         write_size(lat_pkg::CSR_GRID_WIDTH, sizes[i]);
         write_size(lat_pkg::CSR_GRID_HEIGHT, sizes[7 - i]);
         for (int j = 0; j < 30; j++)
            rand_op(eff_dim(width_reg, NCOLS), eff_dim(height_reg, NROWS));
      end
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 8; ph++) begin
         write_size(lat_pkg::CSR_GRID_WIDTH, 7'($urandom_range(1, 12)));
         write_size(lat_pkg::CSR_GRID_HEIGHT, 7'($urandom_range(1, 12)));
         for (int j = 0; j < 45; j++) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            rand_op(eff_dim(width_reg, NCOLS), eff_dim(height_reg, NROWS));
         end
         burst_mode = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      write_size(lat_pkg::CSR_GRID_WIDTH, 7'd8);
      write_size(lat_pkg::CSR_GRID_HEIGHT, 7'd8);
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int j = 0; j < 40; j++) rand_op(8, 8);
      join
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = lat_pkg::CSR_GRID_WIDTH;
      csr_data = '0;
      width_reg = 7'd64;
      height_reg = 7'd64;
      mismatches = 0;
      hold_off = 1'b0;
      burst_mode = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sizes();
      test_random();
      test_backpressure();
      drain();
      repeat (10) @(posedge clock);
      $display("Ran %0d cell operations over %0s grid sizes, with stalls and a long hold-off;",
               transfers_in, "extreme and random");
      $display("%0d results checked, %0d mismatches.", transfers_out, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
